// ===== rtl/core/i2c_master_byte_engine_top_defines.svh =====
// Assertion macros shared by the checkers of the I2C master byte engine.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef I2C_MASTER_BYTE_ENGINE_TOP_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define I2CM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cm: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define I2CM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cm: next-cycle check failed");

`endif

// ===== rtl/core/i2cm_pkg.sv =====
`default_nettype none

package i2cm_pkg;

    // Command codes carried in the mode field; any other code is a tick.
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Configuration register indexes.
    localparam logic REG_HALF_BIT_TICKS  = 1'b0;
    localparam logic REG_STRETCH_RETRIES = 1'b1;

    localparam logic [15:0] HALF_BIT_TICKS_RESET  = 16'd5;
    localparam logic [7:0]  STRETCH_RETRIES_RESET = 8'd10;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       scl_level;
        logic       sda_level;
    } in_item_t;

    typedef struct packed {
        logic       scl_drive;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_received;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2cm_engine.sv =====
`default_nettype none

module i2cm_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire i2cm_pkg::in_item_t item,
    input  wire logic [15:0]       half_bit_ticks,
    input  wire logic [7:0]        stretch_retries,
    output i2cm_pkg::out_item_t    result
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST1,
        PH_ST2,
        PH_ST3,
        PH_SP1,
        PH_SP2,
        PH_SP3,
        PH_BLOW,
        PH_BCHK,
        PH_BSTR,
        PH_BHIGH
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [15:0] wait_reg,   wait_next;
    logic [7:0]  retry_reg,  retry_next;
    logic [3:0]  bit_reg,    bit_next;
    logic [7:0]  shift_reg,  shift_next;
    logic [2:0]  cmd_reg,    cmd_next;
    logic        ackw_reg,   ackw_next;
    logic        scl_reg,    scl_next;
    logic        sda_reg,    sda_next;
    logic        last_ack_reg, last_ack_next;
    logic [7:0]  read_reg,   read_next;
    logic        done;

    logic [15:0] load_val;
    logic        expired;
    logic [15:0] wait_dec;
    logic        is_cmd;
    logic        receive;
    logic [7:0]  gh_shift;
    logic        gh_ack;
    logic [7:0]  hi_shift;
    logic [3:0]  hi_bit;

    // Level driven on SDA while SCL is low at the start of a bit.
    function automatic logic bit_sda(input logic [2:0] cmd, input logic [3:0] idx,
                                     input logic [7:0] shf, input logic ackw);
        logic v;
        if (cmd == i2cm_pkg::CMD_WRITE)
            v = (idx < 4'd8) ? shf[7] : 1'b1;
        else
            v = (idx < 4'd8) ? 1'b1 : ~ackw;
        return v;
    endfunction

    assign load_val = (half_bit_ticks == 16'd0) ? 16'd1 : half_bit_ticks;
    assign expired  = (wait_reg <= 16'd1);
    assign wait_dec = expired ? 16'd0 : wait_reg - 16'd1;
    assign is_cmd   = (item.mode == i2cm_pkg::CMD_START) || (item.mode == i2cm_pkg::CMD_STOP)
                   || (item.mode == i2cm_pkg::CMD_WRITE) || (item.mode == i2cm_pkg::CMD_READ);

    // Sampling done when SCL is seen high (or the stretch wait gives up).
    assign receive  = (cmd_reg == i2cm_pkg::CMD_WRITE) ? (bit_reg == 4'd8) : (bit_reg < 4'd8);
    assign gh_shift = (receive && cmd_reg != i2cm_pkg::CMD_WRITE)
                    ? {shift_reg[6:0], item.sda_level} : shift_reg;
    assign gh_ack   = (receive && cmd_reg == i2cm_pkg::CMD_WRITE)
                    ? ~item.sda_level : last_ack_reg;

    // End of the high half of a bit.
    assign hi_shift = (cmd_reg == i2cm_pkg::CMD_WRITE && bit_reg < 4'd8)
                    ? {shift_reg[6:0], 1'b0} : shift_reg;
    assign hi_bit   = bit_reg + 4'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        wait_next     = wait_reg;
        retry_next    = retry_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        cmd_next      = cmd_reg;
        ackw_next     = ackw_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        last_ack_next = last_ack_reg;
        read_next     = read_reg;
        done          = 1'b0;

        if (step)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (is_cmd)
                begin
                    cmd_next  = item.mode;
                    bit_next  = 4'd0;
                    wait_next = load_val;
                    case (item.mode)
                        i2cm_pkg::CMD_START:
                        begin
                            sda_next   = 1'b1;
                            scl_next   = 1'b1;
                            phase_next = PH_ST1;
                        end
                        i2cm_pkg::CMD_STOP:
                        begin
                            sda_next   = 1'b0;
                            phase_next = PH_SP1;
                        end
                        i2cm_pkg::CMD_WRITE:
                        begin
                            shift_next = item.data_byte;
                            sda_next   = item.data_byte[7];
                            phase_next = PH_BLOW;
                        end
                        default:
                        begin
                            shift_next = 8'd0;
                            ackw_next  = item.send_ack;
                            sda_next   = 1'b1;
                            phase_next = PH_BLOW;
                        end
                    endcase
                end
            end
            else
            begin
                case (phase_reg)
                    PH_ST1, PH_ST2, PH_SP1, PH_SP2:
                    begin
                        if (expired)
                        begin
                            wait_next = load_val;
                            case (phase_reg)
                                PH_ST1:
                                begin
                                    sda_next   = 1'b0;
                                    phase_next = PH_ST2;
                                end
                                PH_ST2:
                                begin
                                    scl_next   = 1'b0;
                                    phase_next = PH_ST3;
                                end
                                PH_SP1:
                                begin
                                    scl_next   = 1'b1;
                                    phase_next = PH_SP2;
                                end
                                default:
                                begin
                                    sda_next   = 1'b1;
                                    phase_next = PH_SP3;
                                end
                            endcase
                        end
                        else
                        begin
                            wait_next = wait_dec;
                        end
                    end
                    PH_ST3, PH_SP3:
                    begin
                        wait_next = wait_dec;
                        if (expired)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    PH_BLOW:
                    begin
                        wait_next = wait_dec;
                        if (expired)
                        begin
                            scl_next   = 1'b1;
                            retry_next = stretch_retries;
                            phase_next = PH_BCHK;
                        end
                    end
                    PH_BCHK:
                    begin
                        wait_next = load_val;
                        if (item.scl_level)
                        begin
                            shift_next    = gh_shift;
                            last_ack_next = gh_ack;
                            phase_next    = PH_BHIGH;
                        end
                        else
                        begin
                            phase_next = PH_BSTR;
                        end
                    end
                    PH_BSTR:
                    begin
                        wait_next = wait_dec;
                        if (expired)
                        begin
                            if (retry_reg == 8'd0)
                            begin
                                // Out of retries: the bit goes on regardless.
                                shift_next    = gh_shift;
                                last_ack_next = gh_ack;
                                wait_next     = load_val;
                                phase_next    = PH_BHIGH;
                            end
                            else
                            begin
                                retry_next = retry_reg - 8'd1;
                                phase_next = PH_BCHK;
                            end
                        end
                    end
                    PH_BHIGH:
                    begin
                        wait_next = wait_dec;
                        if (expired)
                        begin
                            scl_next   = 1'b0;
                            shift_next = hi_shift;
                            bit_next   = hi_bit;
                            if (hi_bit > 4'd8)
                            begin
                                if (cmd_reg == i2cm_pkg::CMD_READ)
                                    read_next = hi_shift;
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            else
                            begin
                                sda_next   = bit_sda(cmd_reg, hi_bit, hi_shift, ackw_reg);
                                wait_next  = load_val;
                                phase_next = PH_BLOW;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            wait_reg     <= 16'd0;
            retry_reg    <= 8'd0;
            bit_reg      <= 4'd0;
            shift_reg    <= 8'd0;
            cmd_reg      <= i2cm_pkg::CMD_TICK;
            ackw_reg     <= 1'b0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            last_ack_reg <= 1'b0;
            read_reg     <= 8'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            wait_reg     <= wait_next;
            retry_reg    <= retry_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            cmd_reg      <= cmd_next;
            ackw_reg     <= ackw_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            last_ack_reg <= last_ack_next;
            read_reg     <= read_next;
        end
    end

    always_comb
    begin
        result.scl_drive    = scl_next;
        result.sda_drive    = sda_next;
        result.busy_res     = (phase_next != PH_IDLE);
        result.done_res     = done;
        result.read_byte    = read_next;
        result.ack_received = last_ack_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/i2c_master_byte_engine_top.sv =====
// I2C master byte engine. Each item is either a timing tick or, while no command is
// running, a start, stop, write-byte or read-byte command; every item returns exactly one
// result with the SCL and SDA drives, busy, a done pulse, the last read byte and the last
// write's ACK. The block takes one item per clock cycle unless a waiting result is held
// back by result_ready, and an item passes through the input register and then the result
// register; the bit engine between them computes its step combinationally. Configuration
// is written through cfg_we, cfg_index and cfg_data and must only change while no command
// is running and no result is outstanding.
`default_nettype none

module i2c_master_byte_engine_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire i2cm_pkg::in_item_t item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output i2cm_pkg::out_item_t    result,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [15:0]       cfg_data
);

    logic                 in_vld_reg;
    i2cm_pkg::in_item_t   in_item_reg;
    logic                 out_vld_reg;
    i2cm_pkg::out_item_t  out_item_reg;
    logic [15:0]          hbt_reg;
    logic [7:0]           retries_reg;
    logic                 advance;
    i2cm_pkg::out_item_t  step_result;

    // The held item moves on whenever the result register is free or being emptied.
    assign advance    = in_vld_reg && (!out_vld_reg || result_ready);
    assign item_ready = !in_vld_reg || advance;

    i2cm_engine u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .item            (in_item_reg),
        .half_bit_ticks  (hbt_reg),
        .stretch_retries (retries_reg),
        .result          (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            hbt_reg     <= i2cm_pkg::HALF_BIT_TICKS_RESET;
            retries_reg <= i2cm_pkg::STRETCH_RETRIES_RESET;
        end
        else
        begin
            if (item_ready)
                in_vld_reg <= item_valid;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (result_ready)
                out_vld_reg <= 1'b0;
            if (cfg_we && cfg_index == i2cm_pkg::REG_HALF_BIT_TICKS)
                hbt_reg <= cfg_data;
            if (cfg_we && cfg_index == i2cm_pkg::REG_STRETCH_RETRIES)
                retries_reg <= cfg_data[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            in_item_reg <= item;
        if (advance)
            out_item_reg <= step_result;
    end

    assign result_valid = out_vld_reg;
    assign result       = out_item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/i2cm_checker.sv =====
`default_nettype none
`include "i2c_master_byte_engine_top_defines.svh"

module i2cm_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_ready,
    input  wire logic                result_valid,
    input  wire logic                result_ready,
    input  wire i2cm_pkg::out_item_t result
);

    // A stalled result must stay put.
    `I2CM_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

    // With no result waiting, the input side can never be blocked.
    `I2CM_ASSERT_IMP(a_ready_when_empty, !result_valid, item_ready)

    // A completing item leaves the engine idle.
    `I2CM_ASSERT_IMP(a_done_not_busy, result_valid && result.done_res, !result.busy_res)

    // The input is held off only by a result that is waiting to be taken.
    `I2CM_ASSERT_IMP(a_item_flows, !item_ready, result_valid && !result_ready)

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_i2cm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
